>>> sv/acmac_pkg.sv
// Shared types, constants and AES helper functions for the CMAC engine.
package acmac_pkg;

    localparam int unsigned NUM_RK  = 15;
    localparam int unsigned RK_AW   = 4;
    localparam logic [7:0]  SUBKEY_POLY = 8'h87;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;

    typedef enum logic [2:0] {
        CFG_KEY0 = 3'd0,
        CFG_KEY1 = 3'd1,
        CFG_KEY2 = 3'd2,
        CFG_KEY3 = 3'd3,
        CFG_KLEN = 3'd4
    } cfg_idx_t;

    localparam logic [1:0] KLEN_128 = 2'd0;
    localparam logic [1:0] KLEN_192 = 2'd1;

    // Request from the control path to the AES core.
    typedef struct packed {
        logic         start;
        logic [127:0] block;
    } aes_req_t;

    // Status returned by the AES core.
    typedef struct packed {
        logic         busy;
        logic         done;
        logic [127:0] result;
    } aes_rsp_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // One AES round; byte 0 sits in bits 127:120.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0]   b [16];
        logic [7:0]   n [16];
        logic [7:0]   a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++)
            b[i] = sbox(s[127 - 8*i -: 8]);
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                n[i + 4*c] = b[i + 4*((c + i) % 4)];
        if (!last)
        begin
            for (int c = 0; c < 4; c++)
            begin
                a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
                al = a0 ^ a1 ^ a2 ^ a3;
                n[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                n[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                n[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                n[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++)
            r[127 - 8*i -: 8] = n[i];
        return r;
    endfunction

    // Left shift by one with the 0x87 feedback.
    function automatic logic [127:0] dbl(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? SUBKEY_POLY : 8'h00)};
    endfunction

endpackage

>>> sv/acmac_if.sv
// Valid/ready channel interfaces for message words and tags.
interface acmac_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last_word;
    modport source (output valid, data_word, byte_count, last_word, input ready);
    modport sink (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface acmac_tag_if;
    logic        valid;
    logic        ready;
    logic [63:0] tag_high;
    logic [63:0] tag_low;
    modport source (output valid, tag_high, tag_low, input ready);
    modport sink (input valid, tag_high, tag_low, output ready);
endinterface

>>> sv/acmac_core.sv
// Iterative AES encryption core with key expansion into a round key memory.
module acmac_core
    import acmac_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         expand,
    input  logic [255:0] key,
    input  logic [1:0]   key_length,
    input  aes_req_t     req,
    output aes_rsp_t     rsp
);

    typedef enum logic [2:0] {ST_INIT, ST_EXP, ST_IDLE, ST_RD0, ST_RUN} state_t;

    // Round key memory, one synchronous read port.
    logic [127:0] rk_mem [NUM_RK];
    logic [127:0] rk_rdata_reg;
    logic [RK_AW-1:0] rd_addr;
    logic             wr_en;
    logic [RK_AW-1:0] wr_addr;
    logic [127:0]     wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            rk_mem[wr_addr] <= wr_data;
        rk_rdata_reg <= rk_mem[rd_addr];
    end

    state_t       state_reg;
    logic [5:0]   wi_reg;          // key word index during expansion
    logic [3:0]   wmod_reg;        // key word index modulo Nk
    logic [255:0] win_reg;         // sliding window of the last eight words
    logic [7:0]   rcon_reg;
    logic [127:0] half_reg;        // words collected for the next round key
    logic [3:0]   rnd_reg;
    logic [127:0] st_reg;
    logic         done_reg;
    logic [127:0] in_reg;

    logic [3:0] nk;
    logic [3:0] nr;
    logic [5:0] total;
    always_comb
    begin
        priority if (key_length == KLEN_128)
        begin
            nk = 4'd4;
        end
        else if (key_length == KLEN_192)
        begin
            nk = 4'd6;
        end
        else
        begin
            nk = 4'd8;
        end
        nr    = nk + 4'd6;
        total = {nr, 2'b00} + 6'd4;
    end

    // Next expanded word from the window (newest word in bits 31:0).
    logic [31:0] prev_w, old_w, t_w, new_w;
    logic [3:0]  wmod;
    always_comb
    begin
        prev_w = win_reg[31:0];
        old_w  = win_reg[32*nk - 1 -: 32];
        wmod   = wmod_reg;
        t_w    = prev_w;
        if (wmod == 4'd0)
            t_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_reg, 24'd0};
        else if (nk == 4'd8 && wmod == 4'd4)
            t_w = sub_word(prev_w);
        new_w = old_w ^ t_w;
    end

    logic [31:0] cur_w;
    assign cur_w = (wi_reg < 6'(nk)) ? key[255 - 32*wi_reg -: 32] : new_w;

    // The read address runs one round ahead so the key is ready when used.
    always_comb
    begin
        wr_en   = (state_reg == ST_EXP) && (wi_reg[1:0] == 2'd3);
        wr_addr = wi_reg[5:2];
        wr_data = {half_reg[95:0], cur_w};
        rd_addr = '0;
        if (state_reg == ST_RD0 || (state_reg == ST_RUN && rnd_reg != nr))
            rd_addr = rnd_reg + 4'd1;
    end

    logic [127:0] rnd_out;
    assign rnd_out = aes_round(st_reg, rnd_reg == nr) ^ rk_rdata_reg;

    // Sequencer for expansion and encryption.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            wi_reg    <= '0;
            wmod_reg  <= '0;
            rcon_reg  <= 8'h01;
            rnd_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (expand)
            begin
                state_reg <= ST_INIT;
            end
            else
            begin
                unique case (state_reg)
                    ST_INIT:
                    begin
                        wi_reg    <= '0;
                        wmod_reg  <= '0;
                        rcon_reg  <= 8'h01;
                        state_reg <= ST_EXP;
                    end
                    ST_EXP:
                    begin
                        win_reg  <= {win_reg[223:0], cur_w};
                        half_reg <= {half_reg[95:0], cur_w};
                        if (wi_reg >= 6'(nk) && wmod == 4'd0)
                            rcon_reg <= xtime(rcon_reg);
                        wi_reg   <= wi_reg + 6'd1;
                        wmod_reg <= (wmod_reg == nk - 4'd1) ? 4'd0 : wmod_reg + 4'd1;
                        if (wi_reg == total - 6'd1)
                            state_reg <= ST_IDLE;
                    end
                    ST_IDLE:
                    begin
                        if (req.start)
                        begin
                            in_reg    <= req.block;
                            rnd_reg   <= '0;
                            state_reg <= ST_RD0;
                        end
                    end
                    ST_RD0:
                    begin
                        st_reg    <= in_reg ^ rk_rdata_reg;
                        rnd_reg   <= 4'd1;
                        state_reg <= ST_RUN;
                    end
                    ST_RUN:
                    begin
                        st_reg <= rnd_out;
                        if (rnd_reg == nr)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            rnd_reg <= rnd_reg + 4'd1;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_INIT;
                    end
                endcase
            end
        end
    end

    // Round key 0 is read while idle; ST_RD0 and ST_RUN prefetch the key of
    // the following round.
    always_comb
    begin
        rsp.busy   = (state_reg != ST_IDLE);
        rsp.done   = done_reg;
        rsp.result = st_reg;
    end

endmodule

>>> sv/aes_cmac_engine.sv
// Top level of the AES-CMAC engine: message buffering, subkeys and tag output.
//
//   Channel   Dir  Beat contents
//   word_in   in   data_word[63:0], byte_count[3:0], last_word
//   tag_out   out  tag_high[63:0], tag_low[63:0]
//   cfg       in   cfg_we, cfg_index[2:0], cfg_data[63:0]
//
// A word that does not push out a held block is merged into the pending block.
// A word that pushes out a held block waits for one AES pass of the single
// iterative round unit. A last word adds up to three passes (subkey, absorb,
// tag). After reset and each key write the round key memory is refilled
// before words are taken. A tag waiting in the output register stalls only
// the next last word.
module aes_cmac_engine
    import acmac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    acmac_word_if.sink  word_in,
    acmac_tag_if.source tag_out
);

    typedef enum logic [2:0] {S_IDLE, S_ABS, S_SUB, S_LABS, S_TAG} state_t;

    logic [255:0] key_reg;
    logic [1:0]   klen_reg;
    logic         expand;

    // Key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            klen_reg <= '0;
            expand   <= 1'b1;
        end
        else
        begin
            expand <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY0: begin key_reg[255:192] <= cfg_data; expand <= 1'b1; end
                    CFG_KEY1: begin key_reg[191:128] <= cfg_data; expand <= 1'b1; end
                    CFG_KEY2: begin key_reg[127:64]  <= cfg_data; expand <= 1'b1; end
                    CFG_KEY3: begin key_reg[63:0]    <= cfg_data; expand <= 1'b1; end
                    CFG_KLEN: begin klen_reg <= cfg_data[1:0]; expand <= 1'b1; end
                    default: ;
                endcase
            end
        end
    end

    aes_req_t req;
    aes_rsp_t rsp;

    acmac_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .expand     (expand),
        .key        (key_reg),
        .key_length (klen_reg),
        .req        (req),
        .rsp        (rsp)
    );

    state_t       state_reg;
    logic [127:0] chain_reg;
    logic [127:0] pend_reg;
    logic [4:0]   cnt_reg;
    logic         start_reg;
    logic [127:0] blk_reg;
    logic [63:0]  word_reg;
    logic [3:0]   wcnt_reg;
    logic         wlast_reg;
    logic         out_v_reg;
    logic [127:0] tag_reg;

    // A word is taken only when the sequencer is idle, no AES pass or key expansion
    // runs or starts, and a last word finds the tag register free.
    logic accept;
    assign word_in.ready = (state_reg == S_IDLE) && !rsp.busy && !start_reg && !expand
                           && !(out_v_reg && word_in.last_word);
    assign accept = word_in.valid && word_in.ready;

    // Effective byte count and merge of a word into the pending block.
    logic [3:0]   eff_cnt;
    assign eff_cnt = (!word_in.last_word || word_in.byte_count > 4'd8) ? 4'd8
                     : word_in.byte_count;

    function automatic logic [127:0] merge(input logic [127:0] p, input logic [4:0] pc,
                                           input logic [63:0] w, input logic [3:0] n);
        logic [127:0] r;
        r = p;
        for (int i = 0; i < 8; i++)
            if (i < n)
                r[127 - 8*(pc + i) -: 8] = w[63 - 8*i -: 8];
        return r;
    endfunction

    // Final block from the pending bytes and the subkeys.
    logic [127:0] k1, k2, fin_blk, pad_blk;
    always_comb
    begin
        k1 = dbl(rsp.result);
        k2 = dbl(k1);
        pad_blk = pend_reg;
        pad_blk[127 - 8*cnt_reg[3:0] -: 8] = PAD_BYTE;
        fin_blk = (cnt_reg == 5'd16) ? (pend_reg ^ k1) : (pad_blk ^ k2);
    end

    always_comb
    begin
        req.start = start_reg;
        req.block = blk_reg;
    end

    // Word absorption and message sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            chain_reg <= '0;
            pend_reg  <= '0;
            cnt_reg   <= '0;
            start_reg <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (tag_out.valid && tag_out.ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        wcnt_reg  <= eff_cnt;
                        wlast_reg <= word_in.last_word;
                        word_reg  <= word_in.data_word;
                        if (cnt_reg == 5'd16 && eff_cnt != 4'd0)
                        begin
                            blk_reg   <= chain_reg ^ pend_reg;
                            start_reg <= 1'b1;
                            state_reg <= S_ABS;
                        end
                        else
                        begin
                            pend_reg <= merge(pend_reg, cnt_reg, word_in.data_word, eff_cnt);
                            cnt_reg  <= cnt_reg + 5'(eff_cnt);
                            if (word_in.last_word)
                            begin
                                blk_reg   <= '0;
                                start_reg <= 1'b1;
                                state_reg <= S_SUB;
                            end
                        end
                    end
                end
                S_ABS:
                begin
                    if (rsp.done)
                    begin
                        chain_reg <= rsp.result;
                        pend_reg  <= merge('0, 5'd0, word_reg, wcnt_reg);
                        cnt_reg   <= 5'(wcnt_reg);
                        if (wlast_reg)
                        begin
                            blk_reg   <= '0;
                            start_reg <= 1'b1;
                            state_reg <= S_SUB;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_SUB:
                begin
                    if (rsp.done)
                    begin
                        blk_reg   <= fin_blk ^ chain_reg;
                        start_reg <= 1'b1;
                        state_reg <= S_TAG;
                    end
                end
                S_TAG:
                begin
                    if (rsp.done)
                    begin
                        tag_reg   <= rsp.result;
                        out_v_reg <= 1'b1;
                        chain_reg <= '0;
                        pend_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign tag_out.valid    = out_v_reg;
    assign tag_out.tag_high = tag_reg[127:64];
    assign tag_out.tag_low  = tag_reg[63:0];

endmodule

>>> test/aes_cmac_engine_tb.sv
// Self-checking testbench for the AES-CMAC engine: directed rows plus random messages.
module aes_cmac_engine_tb
    import acmac_pkg::*;
();

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = CFG_KEY0;
    logic [63:0] cfg_data = '0;
    int unsigned cycle_count = 0;
    int unsigned fail_count = 0;

    acmac_word_if word_ch ();
    acmac_tag_if  tag_ch ();

    aes_cmac_engine dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .word_in(word_ch.sink), .tag_out(tag_ch.source)
    );

    always #2 clk = ~clk;

    // Shadow copy of the key registers and the message state.
    logic [63:0]  key_shadow [4];
    logic [1:0]   klen_shadow;
    logic [7:0]   rk_bytes [240];
    int unsigned  round_total;
    logic [127:0] chain_acc;
    logic [127:0] held_block;
    int unsigned  held_count;
    logic [127:0] tag_queue [$];

    typedef struct {
        logic [63:0]  data;
        logic [3:0]   cnt;
        logic         last;
        bit           known;
        logic [127:0] tag;
    } stim_row_t;

    function automatic logic [7:0] gf2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Expand the shadow key into the round key bytes.
    task automatic rebuild_schedule();
        int unsigned nk;
        int unsigned total;
        logic [7:0]  rc;
        logic [7:0]  t [4];
        logic [7:0]  tmp;
        nk = (klen_shadow == KLEN_128) ? 4 : (klen_shadow == KLEN_192) ? 6 : 8;
        round_total = nk + 6;
        total = 4 * (round_total + 1);
        rc = 8'h01;
        foreach (rk_bytes[i]) rk_bytes[i] = 8'h00;
        for (int i = 0; i < nk * 4; i++)
            rk_bytes[i] = key_shadow[i / 8][63 - 8 * (i % 8) -: 8];
        for (int i = nk; i < total; i++)
        begin
            for (int j = 0; j < 4; j++) t[j] = rk_bytes[(i - 1) * 4 + j];
            if (i % nk == 0)
            begin
                tmp = t[0]; t[0] = t[1]; t[1] = t[2]; t[2] = t[3]; t[3] = tmp;
                for (int j = 0; j < 4; j++) t[j] = sbox(t[j]);
                t[0] ^= rc;
                rc = gf2(rc);
            end
            else if (nk > 6 && i % nk == 4)
            begin
                for (int j = 0; j < 4; j++) t[j] = sbox(t[j]);
            end
            for (int j = 0; j < 4; j++)
                rk_bytes[i * 4 + j] = rk_bytes[(i - nk) * 4 + j] ^ t[j];
        end
    endtask

    function automatic logic [127:0] cipher(input logic [127:0] blk);
        logic [7:0] s [16];
        logic [7:0] n [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] r;
        for (int i = 0; i < 16; i++) s[i] = blk[127 - 8 * i -: 8] ^ rk_bytes[i];
        for (int rnd = 1; rnd <= round_total; rnd++)
        begin
            for (int i = 0; i < 16; i++) s[i] = sbox(s[i]);
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) n[i + 4 * c] = s[i + 4 * ((c + i) % 4)];
            if (rnd != round_total)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    a0 = n[4*c]; a1 = n[4*c+1]; a2 = n[4*c+2]; a3 = n[4*c+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    n[4*c]   = a0 ^ al ^ gf2(a0 ^ a1);
                    n[4*c+1] = a1 ^ al ^ gf2(a1 ^ a2);
                    n[4*c+2] = a2 ^ al ^ gf2(a2 ^ a3);
                    n[4*c+3] = a3 ^ al ^ gf2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) s[i] = n[i] ^ rk_bytes[rnd * 16 + i];
        end
        for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = s[i];
        return r;
    endfunction

    function automatic logic [127:0] subkey_shift(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? 8'h87 : 8'h00)};
    endfunction

    // Fold one accepted word into the shadow state; returns 1 with a tag on a last word.
    function automatic bit absorb_word(input logic [63:0] data, input logic [3:0] cnt,
                                       input logic last, output logic [127:0] tag);
        int unsigned n;
        logic [127:0] l_base, k1, k2, fin;
        n = (!last || cnt > 8) ? 8 : cnt;
        tag = '0;
        for (int i = 0; i < n; i++)
        begin
            if (held_count >= 16)
            begin
                chain_acc = cipher(chain_acc ^ held_block);
                held_block = '0;
                held_count = 0;
            end
            held_block[127 - 8 * held_count -: 8] = data[63 - 8 * i -: 8];
            held_count++;
        end
        if (!last)
            return 1'b0;
        l_base = cipher('0);
        k1 = subkey_shift(l_base);
        k2 = subkey_shift(k1);
        if (held_count >= 16)
            fin = held_block ^ k1;
        else
        begin
            fin = held_block;
            fin[127 - 8 * held_count -: 8] = PAD_BYTE;
            fin ^= k2;
        end
        tag = cipher(fin ^ chain_acc);
        chain_acc = '0;
        held_block = '0;
        held_count = 0;
        return 1'b1;
    endfunction

    // Register write at idle; the shadow follows.
    task automatic write_key_reg(input cfg_idx_t idx, input logic [63:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_KLEN) klen_shadow = value[1:0];
        else key_shadow[idx] = value;
        rebuild_schedule();
    endtask

    // Stop offering words, wait for every expected tag, then let the engine settle.
    task automatic drain_tags();
        word_ch.valid <= 1'b0;
        while (tag_queue.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // The word stays valid after its beat only when the next one follows at once.
    task automatic send_word(input logic [63:0] data, input logic [3:0] cnt,
                             input logic last, input bit known,
                             input logic [127:0] fixed_tag);
        logic [127:0] tag;
        int unsigned gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap != 0)
        begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_ch.valid <= 1'b1;
        word_ch.data_word <= data;
        word_ch.byte_count <= cnt;
        word_ch.last_word <= last;
        @(posedge clk);
        while (!word_ch.ready) @(posedge clk);
        if (absorb_word(data, cnt, last, tag))
            tag_queue.push_back(known ? fixed_tag : tag);
    endtask

    // Random message: mostly whole words, last word of random count.
    task automatic send_message(input int unsigned max_words);
        int unsigned len;
        len = $urandom_range(1, max_words);
        for (int i = 1; i < len; i++)
            send_word({$urandom, $urandom}, ($urandom_range(0, 9) == 0) ?
                      4'($urandom_range(0, 15)) : 4'd8, 1'b0, 1'b0, '0);
        send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b1, 1'b0, '0);
    endtask

    // Tag side: random stalls and comparison against the oldest expectation.
    initial
    begin
        int unsigned stall;
        logic [127:0] want;
        stall = 0;
        tag_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (tag_ch.valid && tag_ch.ready)
            begin
                if (tag_queue.size() == 0)
                begin
                    $error("unexpected tag %h%h", tag_ch.tag_high, tag_ch.tag_low);
                    fail_count++;
                end
                else
                begin
                    want = tag_queue.pop_front();
                    if (tag_ch.tag_high !== want[127:64])
                    begin
                        $error("tag_high expected %h actual %h", want[127:64], tag_ch.tag_high);
                        fail_count++;
                    end
                    if (tag_ch.tag_low !== want[63:0])
                    begin
                        $error("tag_low expected %h actual %h", want[63:0], tag_ch.tag_low);
                        fail_count++;
                    end
                end
                stall = (cycle_count % 3000 < 1000) ? 0 : $urandom_range(0, 17);
                tag_ch.ready <= (stall == 0);
            end
            else if (stall != 0)
            begin
                stall--;
                tag_ch.ready <= (stall == 0);
            end
            else
                tag_ch.ready <= 1'b1;
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Directed rows under the reset key; every tag comes from the predictor.
    stim_row_t rows [14] = '{
        '{64'h0, 4'd0, 1'b1, 1'b0, 128'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 128'h0},
        '{64'h0, 4'd8, 1'b0, 1'b0, 128'h0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 128'h0},
        '{64'h0123_4567_89AB_CDEF, 4'd3, 1'b0, 1'b0, 128'h0},
        '{64'hFEDC_BA98_7654_3210, 4'd15, 1'b0, 1'b0, 128'h0},
        '{64'hA5A5_A5A5_A5A5_A5A5, 4'd8, 1'b1, 1'b0, 128'h0},
        '{64'h8000_0000_0000_0001, 4'd1, 1'b1, 1'b0, 128'h0},
        '{64'h1111_2222_3333_4444, 4'd15, 1'b1, 1'b0, 128'h0},
        '{64'h5555_AAAA_5555_AAAA, 4'd8, 1'b0, 1'b0, 128'h0},
        '{64'h0F0F_0F0F_F0F0_F0F0, 4'd7, 1'b1, 1'b0, 128'h0},
        '{64'hDEAD_BEEF_CAFE_F00D, 4'd8, 1'b0, 1'b0, 128'h0},
        '{64'h0000_0000_FFFF_FFFF, 4'd8, 1'b0, 1'b0, 128'h0},
        '{64'h1234_5678_9ABC_DEF0, 4'd9, 1'b1, 1'b0, 128'h0}
    };

    initial
    begin
        word_ch.valid = 1'b0;
        word_ch.data_word = '0;
        word_ch.byte_count = '0;
        word_ch.last_word = 1'b0;
        foreach (key_shadow[i]) key_shadow[i] = '0;
        klen_shadow = KLEN_128;
        chain_acc = '0;
        held_block = '0;
        held_count = 0;
        rebuild_schedule();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset key.
        foreach (rows[i])
            send_word(rows[i].data, rows[i].cnt, rows[i].last, rows[i].known, rows[i].tag);
        drain_tags();

        // Random phases over every key length, with extreme and random keys.
        for (int phase = 0; phase < 8; phase++)
        begin
            write_key_reg(CFG_KEY0, (phase == 1) ? '1 : {$urandom, $urandom});
            write_key_reg(CFG_KEY1, (phase == 1) ? '1 : {$urandom, $urandom});
            write_key_reg(CFG_KEY2, (phase == 1) ? '1 : {$urandom, $urandom});
            write_key_reg(CFG_KEY3, (phase == 1) ? '1 : {$urandom, $urandom});
            write_key_reg(CFG_KLEN, 64'(phase % 4));
            repeat (70) @(posedge clk);
            for (int m = 0; m < 32; m++)
                send_message((m % 8 == 0) ? 12 : 4);
            drain_tags();
        end

        drain_tags();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
